@@ src/mbfeq_pkg.sv @@
// ----------------------------------------------------------------------------
// Multiband FIR equalizer package
// Shared constants, sequencer states and pipeline tag type.
// ----------------------------------------------------------------------------
`default_nettype none

package mbfeq_pkg;

    // Default filter geometry.
    localparam int TAPS_DEF  = 64;
    localparam int BANDS_DEF = 8;

    // Field widths fixed by the interface.
    localparam int SAMPLE_W = 16;
    localparam int BAND_IN_W = 3;
    localparam int TAP_IN_W  = 6;

    // Q15 rounding shift.
    localparam int RND_SHIFT = 15;

    // Input command codes.
    localparam logic CMD_SAMPLE = 1'b0;
    localparam logic CMD_LOAD   = 1'b1;

    // Sequencer states.
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_RUN,
        ST_DRAIN,
        ST_FINISH
    } state_t;

    // Tag that travels with each product through the MAC pipeline.
    typedef struct packed {
        logic vld;
        logic first;
        logic last;
        logic fin;
    } tag_t;

endpackage : mbfeq_pkg

`default_nettype wire

@@ src/mbfeq_ram.sv @@
// ----------------------------------------------------------------------------
// Generic simple dual-port RAM
// One write port and one read port with a registered read data output.
// ----------------------------------------------------------------------------
`default_nettype none

module mbfeq_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 64,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             clk,
    input  wire logic             we,
    input  wire logic [AW-1:0]    waddr,
    input  wire logic [WIDTH-1:0] wdata,
    input  wire logic             re,
    input  wire logic [AW-1:0]    raddr,
    output logic      [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Registered read port.
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule : mbfeq_ram

`default_nettype wire

@@ src/multiband_fir_equalizer_unit.sv @@
// ----------------------------------------------------------------------------
// Multiband FIR equalizer
// Several FIR bands over one shared sample history, summed with 16-bit wrap.
// ----------------------------------------------------------------------------
//
//  Channel   Handshake            Fields
//  -------   ------------------   ----------------------------------------------
//  input     in_valid/in_ready    cmd, sample, coef_band, coef_tap, coef_value
//  output    out_valid/out_ready  result, overflow
//
// A coefficient load gives no result. One shared 16x16
// multiply-accumulate walks every tap of every band, one product per cycle,
// behind a registered RAM read. Products pass through the RAM read, multiply,
// accumulate and rounding registers into the band total, which is then
// copied into the output register.
// The input is not ready while a sample is being filtered; a finished result
// waits in the output register while new items are accepted, and a second
// result holds the block until the first is taken.
// Reset clears the history valid bits and the write pointer, so the history
// reads as zero; the coefficient store is undefined until written.
//
`default_nettype none

module multiband_fir_equalizer_unit
    import mbfeq_pkg::*;
#(
    parameter int TAPS  = TAPS_DEF,
    parameter int BANDS = BANDS_DEF
) (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       in_valid,
    output logic                            in_ready,
    input  wire logic                       cmd,
    input  wire logic signed [SAMPLE_W-1:0] sample,
    input  wire logic [BAND_IN_W-1:0]       coef_band,
    input  wire logic [TAP_IN_W-1:0]        coef_tap,
    input  wire logic signed [SAMPLE_W-1:0] coef_value,
    output logic                            out_valid,
    input  wire logic                       out_ready,
    output logic signed [SAMPLE_W-1:0]      result,
    output logic                            overflow
);

    localparam int PTR_W   = (TAPS > 1) ? $clog2(TAPS) : 1;
    localparam int BCNT_W  = (BANDS > 1) ? $clog2(BANDS) : 1;
    localparam int CDEPTH  = BANDS * TAPS;
    localparam int CADDR_W = (CDEPTH > 1) ? $clog2(CDEPTH) : 1;
    localparam int PROD_W  = 2 * SAMPLE_W;
    localparam int ACC_W   = PROD_W + 1 + $clog2(TAPS);
    localparam int Q_W     = ACC_W - RND_SHIFT;
    localparam logic [PTR_W-1:0]  TAP_LAST  = PTR_W'(TAPS - 1);
    localparam logic [BCNT_W-1:0] BAND_LAST = BCNT_W'(BANDS - 1);
    localparam logic signed [ACC_W-1:0] RND_HALF = ACC_W'(1 << (RND_SHIFT - 1));

    // ------------------------------------------------------------------
    // Declarations
    // ------------------------------------------------------------------
    state_t state_reg, state_next;

    logic in_xfer, out_xfer;
    logic load_xfer, sample_xfer, load_ok;
    logic issue, load_out;

    logic [PTR_W-1:0]   wp_reg, wp_next;
    logic [PTR_W-1:0]   base_reg;
    logic [PTR_W-1:0]   hidx_reg;
    logic [PTR_W-1:0]   tap_cnt_reg;
    logic [BCNT_W-1:0]  band_cnt_reg;
    logic [CADDR_W-1:0] caddr_reg;
    logic [CADDR_W-1:0] load_addr;
    logic [TAPS-1:0]    hvld_reg;

    tag_t issue_tag, s1_tag_reg, prod_tag_reg, acc_tag_reg, rnd_tag_reg;
    logic s1_hv_reg;

    logic signed [SAMPLE_W-1:0] coef_rdata, hist_rdata, x_val;
    logic signed [PROD_W-1:0]   prod_reg;
    logic signed [ACC_W-1:0]    acc_reg, acc_next;
    logic signed [ACC_W-1:0]    rnd_sum;
    logic signed [Q_W-1:0]      q_val;
    logic signed [SAMPLE_W-1:0] rnd_reg;
    logic                       rnd_ovf_reg;
    logic signed [SAMPLE_W:0]   tot_sum;
    logic signed [SAMPLE_W-1:0] total_reg;
    logic                       tovf_reg;

    logic                       out_valid_reg;
    logic signed [SAMPLE_W-1:0] result_reg;
    logic                       overflow_reg;

    // ------------------------------------------------------------------
    // Handshakes
    // ------------------------------------------------------------------
    assign in_xfer     = in_valid && in_ready;
    assign out_xfer    = out_valid_reg && out_ready;
    assign sample_xfer = in_xfer && (cmd == CMD_SAMPLE);
    assign load_ok     = (32'(coef_band) < BANDS) && (32'(coef_tap) < TAPS);
    assign load_xfer   = in_xfer && (cmd == CMD_LOAD) && load_ok;
    assign load_addr   = CADDR_W'(32'(coef_band) * TAPS + 32'(coef_tap));

    // ------------------------------------------------------------------
    // Sequencer: next state
    // ------------------------------------------------------------------
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (sample_xfer)
                begin
                    state_next = ST_RUN;
                end
            end
            ST_RUN:
            begin
                if (issue_tag.fin)
                begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN:
            begin
                if (rnd_tag_reg.vld && rnd_tag_reg.fin)
                begin
                    state_next = ST_FINISH;
                end
            end
            ST_FINISH:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // ------------------------------------------------------------------
    // Sequencer: outputs
    // ------------------------------------------------------------------
    always_comb
    begin
        in_ready = 1'b0;
        issue    = 1'b0;
        load_out = 1'b0;
        case (state_reg)
            ST_IDLE:   in_ready = 1'b1;
            ST_RUN:    issue    = 1'b1;
            ST_DRAIN:  issue    = 1'b0;
            ST_FINISH: load_out = !out_valid_reg || out_ready;
            default:   in_ready = 1'b0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Tag of the tap being issued this cycle.
    always_comb
    begin
        issue_tag.vld   = issue;
        issue_tag.first = issue && (tap_cnt_reg == '0);
        issue_tag.last  = issue && (tap_cnt_reg == TAP_LAST);
        issue_tag.fin   = issue && (tap_cnt_reg == TAP_LAST) && (band_cnt_reg == BAND_LAST);
    end

    // ------------------------------------------------------------------
    // Write pointer and history valid bits
    // ------------------------------------------------------------------
    assign wp_next = (wp_reg == TAP_LAST) ? '0 : wp_reg + 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg   <= '0;
            hvld_reg <= '0;
        end
        else if (sample_xfer)
        begin
            wp_reg           <= wp_next;
            hvld_reg[wp_reg] <= 1'b1;
        end
    end

    // ------------------------------------------------------------------
    // Tap, band and address counters
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            base_reg     <= '0;
            hidx_reg     <= '0;
            tap_cnt_reg  <= '0;
            band_cnt_reg <= '0;
            caddr_reg    <= '0;
        end
        else if (sample_xfer)
        begin
            base_reg     <= wp_reg;
            hidx_reg     <= wp_reg;
            tap_cnt_reg  <= '0;
            band_cnt_reg <= '0;
            caddr_reg    <= '0;
        end
        else if (issue)
        begin
            caddr_reg <= caddr_reg + 1'b1;
            if (issue_tag.last)
            begin
                // Next band restarts from the newest sample.
                hidx_reg     <= base_reg;
                tap_cnt_reg  <= '0;
                band_cnt_reg <= band_cnt_reg + 1'b1;
            end
            else
            begin
                hidx_reg    <= (hidx_reg == '0) ? TAP_LAST : hidx_reg - 1'b1;
                tap_cnt_reg <= tap_cnt_reg + 1'b1;
            end
        end
    end

    // ------------------------------------------------------------------
    // Memories
    // ------------------------------------------------------------------
    mbfeq_ram #(
        .WIDTH (SAMPLE_W),
        .DEPTH (CDEPTH)
    ) u_coef_ram (
        .clk   (clk),
        .we    (load_xfer),
        .waddr (load_addr),
        .wdata (coef_value),
        .re    (issue),
        .raddr (caddr_reg),
        .rdata (coef_rdata)
    );

    mbfeq_ram #(
        .WIDTH (SAMPLE_W),
        .DEPTH (TAPS)
    ) u_hist_ram (
        .clk   (clk),
        .we    (sample_xfer),
        .waddr (wp_reg),
        .wdata (sample),
        .re    (issue),
        .raddr (hidx_reg),
        .rdata (hist_rdata)
    );

    // ------------------------------------------------------------------
    // MAC pipeline tags
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_tag_reg   <= '0;
            prod_tag_reg <= '0;
            acc_tag_reg  <= '0;
            s1_hv_reg    <= 1'b0;
        end
        else
        begin
            s1_tag_reg   <= issue_tag;
            prod_tag_reg <= s1_tag_reg;
            acc_tag_reg  <= prod_tag_reg;
            s1_hv_reg    <= hvld_reg[hidx_reg];
        end
    end

    // A history entry never written since reset reads as zero.
    assign x_val = s1_hv_reg ? hist_rdata : '0;

    // Multiply stage.
    always_ff @(posedge clk)
    begin
        if (s1_tag_reg.vld)
        begin
            prod_reg <= coef_rdata * x_val;
        end
    end

    // Accumulate stage; the first tap of a band restarts the sum.
    always_comb
    begin
        if (prod_tag_reg.first)
        begin
            acc_next = ACC_W'(prod_reg);
        end
        else
        begin
            acc_next = acc_reg + ACC_W'(prod_reg);
        end
    end

    always_ff @(posedge clk)
    begin
        if (prod_tag_reg.vld)
        begin
            acc_reg <= acc_next;
        end
    end

    // ------------------------------------------------------------------
    // Band rounding: add one half LSB, floor shift by 15, check range
    // ------------------------------------------------------------------
    assign rnd_sum = acc_reg + RND_HALF;
    assign q_val   = Q_W'(rnd_sum >>> RND_SHIFT);

    // Only the last tap of a band carries a valid rounded value onward.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rnd_tag_reg <= '0;
        end
        else
        begin
            rnd_tag_reg <= {acc_tag_reg.vld && acc_tag_reg.last, acc_tag_reg.first,
                            acc_tag_reg.last, acc_tag_reg.fin};
        end
    end

    always_ff @(posedge clk)
    begin
        if (acc_tag_reg.vld && acc_tag_reg.last)
        begin
            rnd_reg     <= q_val[SAMPLE_W-1:0];
            rnd_ovf_reg <= (q_val[Q_W-1:SAMPLE_W-1] != {(Q_W-SAMPLE_W+1){q_val[SAMPLE_W-1]}});
        end
    end

    // ------------------------------------------------------------------
    // Band total with 16-bit wrap and sticky overflow
    // ------------------------------------------------------------------
    assign tot_sum = {rnd_reg[SAMPLE_W-1], rnd_reg} + {total_reg[SAMPLE_W-1], total_reg};

    always_ff @(posedge clk)
    begin
        if (sample_xfer)
        begin
            total_reg <= '0;
            tovf_reg  <= 1'b0;
        end
        else if (rnd_tag_reg.vld)
        begin
            total_reg <= tot_sum[SAMPLE_W-1:0];
            tovf_reg  <= tovf_reg || rnd_ovf_reg
                         || (tot_sum[SAMPLE_W] != tot_sum[SAMPLE_W-1]);
        end
    end

    // ------------------------------------------------------------------
    // Output register
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (load_out)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_xfer)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load_out)
        begin
            result_reg   <= total_reg;
            overflow_reg <= tovf_reg;
        end
    end

    assign out_valid = out_valid_reg;
    assign result    = result_reg;
    assign overflow  = overflow_reg;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    // The MAC pipeline is empty whenever the block waits for input.
    a_idle_empty : assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_IDLE |-> !(s1_tag_reg.vld || prod_tag_reg.vld
                                   || acc_tag_reg.vld || rnd_tag_reg.vld))
        else $error("MAC pipeline busy while idle");

    // The band counter stays inside the configured band count.
    a_band_range : assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_RUN |-> 32'(band_cnt_reg) < BANDS)
        else $error("band counter out of range");

    // A new result appears only out of the finish state.
    a_out_src : assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg == ST_FINISH))
        else $error("result loaded outside finish state");

    // The last band's rounded value arrives only while draining.
    a_fin_drain : assert property (@(posedge clk) disable iff (!rst_n)
        rnd_tag_reg.vld && rnd_tag_reg.fin |-> state_reg == ST_DRAIN)
        else $error("final band finished outside drain");

endmodule : multiband_fir_equalizer_unit

`default_nettype wire

@@ bench/tb_multiband_fir_equalizer_unit.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Multiband FIR equalizer testbench
// Loads Q15 coefficients and streams samples through the equalizer. Every
// sample transfer is run through a local equalizer model, and each result
// transfer is checked against the oldest predicted output. Directed tests
// cover rounding, tap alignment and both overflow paths. Random streams then
// run with input stalls, with output stalls and with none.
// ----------------------------------------------------------------------------

module tb_multiband_fir_equalizer_unit;
    import mbfeq_pkg::*;

    localparam int TAPS        = TAPS_DEF;
    localparam int BANDS       = BANDS_DEF;
    localparam int STALL_LIMIT = 4000;
    localparam int SETTLE      = BANDS * TAPS + 32;
    localparam int PHASE_ITEMS = 120;

    // Predicted output of one filtered sample.
    typedef struct {
        logic signed [SAMPLE_W-1:0] level;
        logic                       wrapped;
    } eq_out_t;

    logic                       clk = 1'b0;
    logic                       rst_n = 1'b0;
    logic                       in_valid;
    logic                       in_ready;
    logic                       cmd;
    logic signed [SAMPLE_W-1:0] sample;
    logic [BAND_IN_W-1:0]       coef_band;
    logic [TAP_IN_W-1:0]        coef_tap;
    logic signed [SAMPLE_W-1:0] coef_value;
    logic                       out_valid;
    logic                       out_ready = 1'b0;
    logic signed [SAMPLE_W-1:0] result;
    logic                       overflow;

    // Model state: sample history, write pointer and coefficient store.
    logic signed [SAMPLE_W-1:0] tap_history [TAPS];
    int                         hist_wr_ptr;
    logic signed [SAMPLE_W-1:0] coef_mem [BANDS][TAPS];

    eq_out_t filtered_q [$];

    int send_idle_pct = 11;
    int recv_idle_pct = 80;
    int mismatches = 0;
    int samples_sent = 0;
    int loads_sent = 0;
    int results_checked = 0;
    int wraps_seen = 0;
    int stall_cycles = 0;

    multiband_fir_equalizer_unit dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .cmd        (cmd),
        .sample     (sample),
        .coef_band  (coef_band),
        .coef_tap   (coef_tap),
        .coef_value (coef_value),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .result     (result),
        .overflow   (overflow)
    );

    // 10 ns clock.
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Print one mismatch line and count it.
    task automatic report_mismatch(input string msg);
        $display("%0t ns  mismatch: %s", $time, msg);
        mismatches++;
    endtask

    // Store a sample in the history and run every band over the last TAPS
    // samples, newest first; bands are rounded and summed with 16-bit wrap.
    function automatic eq_out_t equalize_sample(input logic signed [SAMPLE_W-1:0] x);
        eq_out_t                    o;
        longint                     acc;
        longint                     q;
        int                         idx;
        int                         t;
        logic signed [SAMPLE_W-1:0] r;
        logic signed [SAMPLE_W-1:0] sum16;
        tap_history[hist_wr_ptr] = x;
        sum16 = '0;
        o.wrapped = 1'b0;
        for (int b = 0; b < BANDS; b++)
        begin
            acc = 0;
            idx = hist_wr_ptr;
            for (int k = 0; k < TAPS; k++)
            begin
                acc += longint'(coef_mem[b][k]) * longint'(tap_history[idx]);
                idx = (idx == 0) ? TAPS - 1 : idx - 1;
            end
            // Round half up, then floor shift.
            q = (acc + 64'sh4000) >>> RND_SHIFT;
            if (q < -32768 || q > 32767)
                o.wrapped = 1'b1;
            r = q[SAMPLE_W-1:0];
            t = int'(sum16) + int'(r);
            if (t < -32768 || t > 32767)
                o.wrapped = 1'b1;
            sum16 = t[SAMPLE_W-1:0];
        end
        hist_wr_ptr = (hist_wr_ptr + 1 >= TAPS) ? 0 : hist_wr_ptr + 1;
        o.level = sum16;
        return o;
    endfunction

    function automatic logic signed [SAMPLE_W-1:0] pick_extreme();
        case ($urandom_range(0, 4))
            0: return 16'h7FFF;
            1: return 16'h8000;
            2: return 16'hFFFF;
            3: return 16'h0000;
            default: return 16'h0001;
        endcase
    endfunction

    function automatic logic signed [SAMPLE_W-1:0] pick_small(input int lim);
        return SAMPLE_W'(int'($urandom_range(0, 2 * lim)) - lim);
    endfunction

    function automatic logic signed [SAMPLE_W-1:0] pick_sample();
        int sel;
        sel = $urandom_range(0, 99);
        if (sel < 50)
            return SAMPLE_W'($urandom);
        else if (sel < 80)
            return pick_small(1024);
        else
            return pick_extreme();
    endfunction

    // Mostly small coefficients so that many outputs stay in range.
    function automatic logic signed [SAMPLE_W-1:0] pick_coef(input int lim);
        int sel;
        sel = $urandom_range(0, 99);
        if (sel < 70)
            return pick_small(lim);
        else if (sel < 85)
            return pick_extreme();
        else
            return SAMPLE_W'($urandom);
    endfunction

    // Send one item; the model is updated at the transfer. Valid stays high
    // afterwards so the next item can follow without a gap.
    task automatic send_item(input logic                       c,
                             input logic signed [SAMPLE_W-1:0] s,
                             input logic [BAND_IN_W-1:0]       b,
                             input logic [TAP_IN_W-1:0]        k,
                             input logic signed [SAMPLE_W-1:0] v);
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid   <= 1'b1;
        cmd        <= c;
        sample     <= s;
        coef_band  <= b;
        coef_tap   <= k;
        coef_value <= v;
        do
            @(posedge clk);
        while (!in_ready);
        if (c == CMD_LOAD)
        begin
            if (int'(b) < BANDS && int'(k) < TAPS)
                coef_mem[b][k] = v;
            loads_sent++;
        end
        else
        begin
            filtered_q.push_back(equalize_sample(s));
            samples_sent++;
        end
    endtask

    task automatic load_coef(input int b, input int k, input logic signed [SAMPLE_W-1:0] v);
        send_item(CMD_LOAD, SAMPLE_W'($urandom), BAND_IN_W'(b), TAP_IN_W'(k), v);
    endtask

    task automatic push_sample(input logic signed [SAMPLE_W-1:0] x);
        send_item(CMD_SAMPLE, x, BAND_IN_W'($urandom), TAP_IN_W'($urandom),
                  SAMPLE_W'($urandom));
    endtask

    // Write every coefficient; a limit of zero clears the store.
    task automatic fill_coefficients(input int lim);
        for (int b = 0; b < BANDS; b++)
            for (int k = 0; k < TAPS; k++)
                load_coef(b, k, (lim == 0) ? '0 : pick_small(lim));
    endtask

    // Drop valid and wait until every predicted
    // output has been checked.
    task automatic wait_for_results();
        in_valid <= 1'b0;
        @(posedge clk);
        while (filtered_q.size() != 0)
            @(posedge clk);
    endtask

    // Every coefficient must be written before the first sample.
    task automatic test_clear_coefficients();
        fill_coefficients(0);
    endtask

    // Single tap of one: exercises the round-half-up and floor behavior.
    task automatic test_rounding();
        load_coef(0, 0, 16'sd1);
        push_sample(16'sh4000);
        push_sample(-16'sh4000);
        push_sample(-16'sh4001);
        push_sample(16'sh3FFF);
        push_sample(16'sh7FFF);
        push_sample(16'h8000);
        wait_for_results();
    endtask

    // An impulse walks through later taps; the highest band and tap also get a coefficient.
    task automatic test_tap_order();
        load_coef(0, 0, 16'sd0);
        load_coef(2, 1, 16'h7FFF);
        load_coef(5, 3, 16'h8000);
        load_coef(7, 63, 16'h7FFF);
        push_sample(16'h7FFF);
        push_sample(16'sd0);
        push_sample(16'sd0);
        push_sample(16'sd0);
        push_sample(16'h8000);
        wait_for_results();
    endtask

    // Full-scale products overflow each band; near-full-scale bands wrap the sum.
    task automatic test_overflow();
        for (int b = 0; b < BANDS; b++)
            load_coef(b, 0, 16'h8000);
        push_sample(16'h8000);
        push_sample(16'h7FFF);
        wait_for_results();
    endtask

    // Random coefficient loads mixed into a random sample stream.
    task automatic test_random_stream(input int send_pct, input int recv_pct, input int lim);
        send_idle_pct = send_pct;
        recv_idle_pct = recv_pct;
        for (int n = 0; n < PHASE_ITEMS; n++)
        begin
            if ($urandom_range(0, 99) < 25)
                send_item(CMD_LOAD, SAMPLE_W'($urandom), BAND_IN_W'($urandom),
                          TAP_IN_W'($urandom), pick_coef(lim));
            else
                push_sample(pick_sample());
        end
        wait_for_results();
    endtask

    // Check each result transfer and drive the output stall pattern.
    always @(posedge clk)
    begin : check_results
        eq_out_t want;
        if (rst_n)
        begin
            if (out_valid && out_ready)
            begin
                if (filtered_q.size() == 0)
                    report_mismatch($sformatf("result %0d with no sample pending", result));
                else
                begin
                    want = filtered_q.pop_front();
                    if (result !== want.level)
                        report_mismatch($sformatf("result %0d, predicted %0d",
                                                  result, want.level));
                    if (overflow !== want.wrapped)
                        report_mismatch($sformatf("overflow %b, predicted %b",
                                                  overflow, want.wrapped));
                    if (want.wrapped)
                        wraps_seen++;
                    results_checked++;
                end
            end
            out_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
        end
    end

    // Watchdog: end the run when no transfer happens for too long.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((in_valid && in_ready) || (out_valid && out_ready))
                stall_cycles <= 0;
            else
                stall_cycles <= stall_cycles + 1;
            if (stall_cycles >= STALL_LIMIT)
            begin
                $display("watchdog: no transfer for %0d cycles", stall_cycles);
                $display("== FAIL ==");
                $finish;
            end
        end
    end

    initial
    begin
        in_valid   <= 1'b0;
        cmd        <= CMD_SAMPLE;
        sample     <= '0;
        coef_band  <= '0;
        coef_tap   <= '0;
        coef_value <= '0;
        hist_wr_ptr = 0;
        for (int k = 0; k < TAPS; k++)
            tap_history[k] = '0;

        // Hold reset, then release it.
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_clear_coefficients();
        test_rounding();
        test_tap_order();
        test_overflow();
        test_random_stream(11, 80, 255);
        test_random_stream(80, 11, 2047);
        test_random_stream(0, 0, 63);

        // Let any trailing load finish and catch stray results.
        wait_for_results();
        repeat (SETTLE) @(posedge clk);
        while (filtered_q.size() != 0)
            report_mismatch($sformatf("output %0d never arrived",
                                      filtered_q.pop_front().level));

        $display("Filtered %0d samples (%0d checked, %0d flagged overflow), %0d loads.",
                 samples_sent, results_checked, wraps_seen, loads_sent);
        $display("Directed rounding, tap order and overflow, then random streams %s",
                 "with input stalls, output stalls and none.");
        if (mismatches == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule

@@ sim.f @@
src/mbfeq_pkg.sv
src/mbfeq_ram.sv
src/multiband_fir_equalizer_unit.sv
bench/tb_multiband_fir_equalizer_unit.sv
